// ===== design/bbt_pkg.sv =====
// ----------------------------------------------------------------------------
// bbt_pkg
// Shared widths, register codes and unit status type for the band tracker.
// ----------------------------------------------------------------------------
package bbt_pkg;

   localparam int PRICE_W       = 24;
   localparam int N_W           = 7;
   localparam int BF_W          = 16;
   localparam int BF_FRAC       = 12;
   localparam int FRACTION_BITS = 8;
   localparam int SUM_W         = PRICE_W + N_W;
   localparam int PSQ_W         = 2 * PRICE_W;
   localparam int SQ_W          = PSQ_W + N_W;
   localparam int VAR_W         = 2 * SUM_W;
   localparam int ROOT_W        = (VAR_W + 2 * FRACTION_BITS) / 2;
   localparam int DVD_W         = ROOT_W;
   localparam int OFS_W         = BF_W + ROOT_W - BF_FRAC;
   localparam int MID_W         = 32;
   localparam int UPPER_W       = 37;
   localparam int LOWER_W       = 38;
   localparam int CSR_IDX_W     = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_FACTOR   = 1'b1;

   localparam logic [N_W-1:0]  WINDOW_LENGTH_RESET = 7'd20;
   localparam logic [BF_W-1:0] BAND_FACTOR_RESET   = 16'd8192;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// ===== design/bbt_ram.sv =====
// ----------------------------------------------------------------------------
// bbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bbt_div_serial.sv =====
// ----------------------------------------------------------------------------
// bbt_div_serial
// Restoring divider, one quotient bit per cycle, dividend shifted msb first.
// ----------------------------------------------------------------------------
module bbt_div_serial
   import bbt_pkg::*;
#(
   parameter int DVD_BITS = 39,
   parameter int DIV_BITS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0] divisor,
   output unit_status_type     status,
   output logic [DVD_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_BITS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_BITS - 1);

   logic [DVD_BITS-1:0] dvd_ff, dvd_in;
   logic [DIV_BITS:0]   rem_ff, rem_in;
   logic [DIV_BITS-1:0] dsr_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                busy_ff, done_ff;
   logic [DIV_BITS:0]   trial;
   logic                take;

   always_comb begin
      trial  = {rem_ff[DIV_BITS-1:0], dvd_ff[DVD_BITS-1]};
      take   = trial >= {1'b0, dsr_ff};
      rem_in = take ? (trial - {1'b0, dsr_ff}) : trial;
      dvd_in = {dvd_ff[DVD_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            dvd_ff <= dvd_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = dvd_ff;

endmodule

// ===== design/bbt_sqrt_serial.sv =====
// ----------------------------------------------------------------------------
// bbt_sqrt_serial
// Integer square root, one root bit per cycle from two radicand bits.
// ----------------------------------------------------------------------------
module bbt_sqrt_serial
   import bbt_pkg::*;
#(
   parameter int RT_BITS = 39
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2*RT_BITS-1:0]   radicand,
   output unit_status_type        status,
   output logic [RT_BITS-1:0]     root
);

   localparam int RAD_W = 2 * RT_BITS;
   localparam int REM_W = RT_BITS + 3;
   localparam int CNT_W = $clog2(RT_BITS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(RT_BITS - 1);

   logic [RAD_W-1:0]   rad_ff;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [RT_BITS-1:0] root_ff, root_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff, done_ff;
   logic [REM_W-1:0]   shifted, trial;
   logic               take;

   always_comb begin
      shifted = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      take    = shifted >= trial;
      rem_in  = take ? (shifted - trial) : shifted;
      root_in = {root_ff[RT_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
            rem_ff  <= rem_in;
            root_ff <= root_in;
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

// ===== design/bollinger_band_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// bollinger_band_tracker_unit
// Rolling window mean and deviation bands over a stream of closing prices.
// ----------------------------------------------------------------------------
// channel | ports                               | direction
// req     | req_valid req_ready req_close_price | in
// rsp     | rsp_valid rsp_ready rsp_*           | out
// csr     | csr_wr_en csr_index csr_wdata       | in, write only
//
// a warm-up beat passes the read, update and finish states; a full window
// beat also passes multiply, variance, square root, divide and offset, where
// the 39-step serial square root and 39-step serial divider follow each other
// one beat is worked at a time; the next is taken while a result waits
// reset is synchronous; the price ring needs no clearing pass
// ----------------------------------------------------------------------------
module bollinger_band_tracker_unit
   import bbt_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [PRICE_W-1:0]        req_close_price,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_bands_ready,
   output logic [MID_W-1:0]          rsp_middle_band,
   output logic [UPPER_W-1:0]        rsp_upper_band,
   output logic signed [LOWER_W-1:0] rsp_lower_band,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [BF_W-1:0]           csr_wdata
);

   localparam int POS_W = $clog2(MAX_WINDOW);
   localparam int CMP_W = POS_W + N_W + 1;
   localparam int WIDE_W = OFS_W + 1;
   localparam logic [WIDE_W-1:0] UPPER_MAX = WIDE_W'((64'd1 << UPPER_W) - 64'd1);
   localparam logic [WIDE_W-1:0] NEG_MAX   = WIDE_W'(64'd1 << (LOWER_W - 1));

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_UPDATE, ST_MULT, ST_VAR,
      ST_SQRT, ST_SDDIV, ST_OFFSET, ST_FINISH
   } state_type;

   state_type state_ff;

   logic [N_W-1:0]     wlen_ff;
   logic [BF_W-1:0]    bf_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [N_W-1:0]     seen_ff;
   logic [PRICE_W-1:0] price_ff, old_ff;
   logic [PSQ_W-1:0]   psq_ff, osq_ff;
   logic               full_ff, ready_ff;
   logic [VAR_W-1:0]   nsq_ff, ssq_ff;
   logic [OFS_W-1:0]   offset_ff;

   logic                      rsp_valid_ff, rsp_bands_ff;
   logic [MID_W-1:0]          rsp_mid_ff;
   logic [UPPER_W-1:0]        rsp_upper_ff;
   logic [LOWER_W-1:0]        rsp_lower_ff;

   logic [N_W-1:0]     n_eff;
   logic [POS_W-1:0]   pos_use, pos_in;
   logic [N_W-1:0]     seen_in;
   logic [PRICE_W-1:0] ram_rd_data;
   logic               accept;
   logic [VAR_W-1:0]   var_diff;

   logic                   mid_start, sqrt_start, sd_start;
   unit_status_type        mid_stat, sqrt_stat, sd_stat;
   logic [DVD_W-1:0]       mid_q, sd_q;
   logic [ROOT_W-1:0]      root;
   logic [BF_W+ROOT_W-1:0] ofs_prod;

   logic [WIDE_W-1:0]  mid_ext, ofs_ext, upper_sum, neg;
   logic [UPPER_W-1:0] upper_val;
   logic [LOWER_W-1:0] lower_val;

   always_comb begin
      if (wlen_ff == '0) begin
         n_eff = N_W'(1);
      end else if (int'(wlen_ff) > MAX_WINDOW) begin
         n_eff = N_W'(MAX_WINDOW);
      end else begin
         n_eff = wlen_ff;
      end
      pos_use = (CMP_W'(pos_ff) >= CMP_W'(n_eff)) ? '0 : pos_ff;
      pos_in  = (CMP_W'(pos_use) + CMP_W'(1) >= CMP_W'(n_eff)) ? '0 : pos_use + 1'b1;
      seen_in = (seen_ff < n_eff) ? seen_ff + 1'b1 : seen_ff;
      accept  = req_valid && req_ready;
      var_diff = nsq_ff - ssq_ff;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign mid_start  = (state_ff == ST_MULT);
   assign sqrt_start = (state_ff == ST_VAR);
   assign sd_start   = (state_ff == ST_SQRT) && sqrt_stat.done;
   assign ofs_prod   = (BF_W+ROOT_W)'(bf_ff) * (BF_W+ROOT_W)'(sd_q);

   // band assembly with saturation on both sides
   always_comb begin
      mid_ext   = WIDE_W'(mid_q);
      ofs_ext   = WIDE_W'(offset_ff);
      upper_sum = mid_ext + ofs_ext;
      upper_val = (upper_sum > UPPER_MAX) ? UPPER_MAX[UPPER_W-1:0] : upper_sum[UPPER_W-1:0];
      neg       = ofs_ext - mid_ext;
      if (ofs_ext > mid_ext) begin
         if (neg > NEG_MAX) begin
            neg = NEG_MAX;
         end
         lower_val = LOWER_W'(0) - neg[LOWER_W-1:0];
      end else begin
         lower_val = mid_ext[LOWER_W-1:0] - ofs_ext[LOWER_W-1:0];
      end
   end

   bbt_ram #(
      .WIDTH(PRICE_W),
      .DEPTH(MAX_WINDOW)
   ) u_ring (
      .clock  (clock),
      .wr_en  (state_ff == ST_READ),
      .wr_addr(pos_use),
      .wr_data(price_ff),
      .rd_en  (accept),
      .rd_addr(pos_use),
      .rd_data(ram_rd_data)
   );

   bbt_div_serial #(
      .DVD_BITS(DVD_W),
      .DIV_BITS(N_W)
   ) u_mid_div (
      .clock   (clock),
      .reset   (reset),
      .start   (mid_start),
      .dividend(DVD_W'({sum_ff, {FRACTION_BITS{1'b0}}})),
      .divisor (n_eff),
      .status  (mid_stat),
      .quotient(mid_q)
   );

   bbt_sqrt_serial #(
      .RT_BITS(ROOT_W)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .radicand({var_diff, {(2*FRACTION_BITS){1'b0}}}),
      .status  (sqrt_stat),
      .root    (root)
   );

   bbt_div_serial #(
      .DVD_BITS(DVD_W),
      .DIV_BITS(N_W)
   ) u_sd_div (
      .clock   (clock),
      .reset   (reset),
      .start   (sd_start),
      .dividend(DVD_W'(root)),
      .divisor (n_eff),
      .status  (sd_stat),
      .quotient(sd_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= WINDOW_LENGTH_RESET;
         bf_ff        <= BAND_FACTOR_RESET;
         sum_ff       <= '0;
         sq_ff        <= '0;
         pos_ff       <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result in the same cycle takes the slot directly
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_WINDOW_LENGTH: begin
                  wlen_ff <= csr_wdata[N_W-1:0];
                  sum_ff  <= '0;
                  sq_ff   <= '0;
                  pos_ff  <= '0;
                  seen_ff <= '0;
               end
               CSR_BAND_FACTOR: begin
                  bf_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  price_ff <= req_close_price;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               old_ff   <= ram_rd_data;
               osq_ff   <= PSQ_W'(ram_rd_data) * PSQ_W'(ram_rd_data);
               psq_ff   <= PSQ_W'(price_ff) * PSQ_W'(price_ff);
               full_ff  <= (seen_ff >= n_eff);
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               sum_ff   <= sum_ff - (full_ff ? SUM_W'(old_ff) : '0) + SUM_W'(price_ff);
               sq_ff    <= sq_ff - (full_ff ? SQ_W'(osq_ff) : '0) + SQ_W'(psq_ff);
               pos_ff   <= pos_in;
               seen_ff  <= seen_in;
               ready_ff <= (seen_in >= n_eff);
               state_ff <= (seen_in >= n_eff) ? ST_MULT : ST_FINISH;
            end
            ST_MULT: begin
               nsq_ff   <= VAR_W'(n_eff) * VAR_W'(sq_ff);
               ssq_ff   <= VAR_W'(sum_ff) * VAR_W'(sum_ff);
               state_ff <= ST_VAR;
            end
            ST_VAR: begin
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               if (sqrt_stat.done) begin
                  state_ff <= ST_SDDIV;
               end
            end
            ST_SDDIV: begin
               if (sd_stat.done) begin
                  state_ff <= ST_OFFSET;
               end
            end
            ST_OFFSET: begin
               offset_ff <= ofs_prod[BF_W+ROOT_W-1:BF_FRAC];
               state_ff  <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_bands_ff <= ready_ff;
                  rsp_mid_ff   <= ready_ff ? mid_q[MID_W-1:0] : '0;
                  rsp_upper_ff <= ready_ff ? upper_val : '0;
                  rsp_lower_ff <= ready_ff ? lower_val : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bands_ready = rsp_bands_ff;
   assign rsp_middle_band = rsp_mid_ff;
   assign rsp_upper_band  = rsp_upper_ff;
   assign rsp_lower_band  = rsp_lower_ff;

`ifndef NO_ASSERTIONS
   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= n_eff)
      else $error("seen count beyond window length");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(pos_ff) < CMP_W'(n_eff))
      else $error("write position outside window");

   a_sqrt_owner: assert property (@(posedge clock) disable iff (reset)
      sqrt_stat.busy |-> (state_ff == ST_SQRT))
      else $error("square root running outside its state");

   a_mid_before_sd: assert property (@(posedge clock) disable iff (reset)
      sd_stat.done |-> !mid_stat.busy)
      else $error("mean division still running when deviation is done");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_READ))
      else $error("accepted beat did not start a read");
`endif

endmodule
